// ----- hdl/tcx_pkg.sv -----
// tcx_pkg: shared types, opcodes and sizes for the execute step block
// no dependencies; used by every other file of the block but tcx_ram

package tcx_pkg;

   localparam int REG_COUNT     = 16;
   localparam int REG_AW        = $clog2(REG_COUNT);
   localparam int DATA_W        = 16;
   localparam int PC_W          = 12;
   localparam int PLEN_W        = 13;
   localparam int REQ_TDATA_W   = 16;
   localparam int RSP_TDATA_W   = 40;
   localparam int CSR_AW        = 3;

   localparam logic [PLEN_W-1:0] PLEN_RESET = 13'd4096;
   localparam logic [CSR_AW-1:0] CSR_PROGRAM_LENGTH = 3'd0;
   localparam logic [DATA_W-1:0] SLT_TRUE = 16'd32767;

   localparam logic [3:0] OP_AND = 4'd0;
   localparam logic [3:0] OP_OR  = 4'd1;
   localparam logic [3:0] OP_XOR = 4'd2;
   localparam logic [3:0] OP_NOT = 4'd3;
   localparam logic [3:0] OP_ADD = 4'd4;
   localparam logic [3:0] OP_SUB = 4'd5;
   localparam logic [3:0] OP_MUL = 4'd6;
   localparam logic [3:0] OP_SLT = 4'd7;
   localparam logic [3:0] OP_SHL = 4'd8;
   localparam logic [3:0] OP_SAR = 4'd9;
   localparam logic [3:0] OP_MOV = 4'd10;
   localparam logic [3:0] OP_LIT = 4'd11;
   localparam logic [3:0] OP_IMM = 4'd12;
   localparam logic [3:0] OP_JMP = 4'd13;
   localparam logic [3:0] OP_BZ  = 4'd14;
   localparam logic [3:0] OP_BNZ = 4'd15;

   typedef struct packed {
      logic [3:0] field_c;
      logic [3:0] field_b;
      logic [3:0] field_a;
      logic [3:0] mode;
   } instr_type;

   typedef struct packed {
      logic                     finished;
      logic signed [DATA_W-1:0] write_value;
      logic [REG_AW-1:0]        write_index;
      logic                     write_happened;
      logic [PC_W-1:0]          next_pc;
   } result_type;

   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      logic [DATA_W-1:0] data;
   } rf_write_type;

endpackage

// ----- hdl/tcx_ram.sv -----
// tcx_ram: generic ram, one write port and two registered read ports
// no dependencies

module tcx_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data0,
   output logic [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] q0_ff;
   logic [WIDTH-1:0] q1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q0_ff <= mem_ff[rd_addr0];
         q1_ff <= mem_ff[rd_addr1];
      end
   end

   assign rd_data0 = q0_ff;
   assign rd_data1 = q1_ff;

endmodule

// ----- hdl/tcx_regfile.sv -----
// tcx_regfile: 16 x 16-bit register file on tcx_ram with valid bits and
// a bypass of the last write; depends on tcx_pkg and tcx_ram

module tcx_regfile (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [tcx_pkg::REG_AW-1:0] rd_addr0,
   input  logic [tcx_pkg::REG_AW-1:0] rd_addr1,
   output logic [tcx_pkg::DATA_W-1:0] rd_data0,
   output logic [tcx_pkg::DATA_W-1:0] rd_data1,
   input  tcx_pkg::rf_write_type      wr
);

   logic [tcx_pkg::REG_COUNT-1:0] valid_ff;
   logic [tcx_pkg::REG_AW-1:0]    addr0_ff;
   logic [tcx_pkg::REG_AW-1:0]    addr1_ff;
   logic                          vld0_ff;
   logic                          vld1_ff;
   tcx_pkg::rf_write_type         last_ff;
   logic [tcx_pkg::DATA_W-1:0]    q0;
   logic [tcx_pkg::DATA_W-1:0]    q1;

   tcx_ram #(
      .WIDTH(tcx_pkg::DATA_W),
      .DEPTH(tcx_pkg::REG_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr0(rd_addr0),
      .rd_addr1(rd_addr1),
      .rd_data0(q0),
      .rd_data1(q1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         last_ff.en <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
            last_ff.en        <= 1'b1;
         end
      end
      if (wr.en) begin
         last_ff.addr <= wr.addr;
         last_ff.data <= wr.data;
      end
      if (rd_en) begin
         addr0_ff <= rd_addr0;
         addr1_ff <= rd_addr1;
         vld0_ff  <= valid_ff[rd_addr0];
         vld1_ff  <= valid_ff[rd_addr1];
      end
   end

   // last write wins over the registered ram data
   always_comb begin
      if (last_ff.en && last_ff.addr == addr0_ff) begin
         rd_data0 = last_ff.data;
      end else begin
         rd_data0 = vld0_ff ? q0 : '0;
      end
      if (last_ff.en && last_ff.addr == addr1_ff) begin
         rd_data1 = last_ff.data;
      end else begin
         rd_data1 = vld1_ff ? q1 : '0;
      end
   end

endmodule

// ----- hdl/tcx_exec.sv -----
// tcx_exec: alu, load and branch logic for one instruction
// depends on tcx_pkg

module tcx_exec (
   input  tcx_pkg::instr_type         instr,
   input  logic [tcx_pkg::DATA_W-1:0] opnd_x,
   input  logic [tcx_pkg::DATA_W-1:0] opnd_y,
   input  logic [tcx_pkg::PC_W-1:0]   pc,
   input  logic [tcx_pkg::PLEN_W-1:0] program_length,
   output tcx_pkg::result_type        result
);

   logic [7:0]                 imm;
   logic [tcx_pkg::DATA_W-1:0] imm_ext;
   logic [2*tcx_pkg::DATA_W-1:0] prod;
   logic                       wr;
   logic [tcx_pkg::DATA_W-1:0] val;
   logic                       taken;
   logic [tcx_pkg::PC_W-1:0]   offset;
   logic [tcx_pkg::PC_W-1:0]   npc;

   always_comb begin
      imm     = {instr.field_b, instr.field_c};
      imm_ext = {{(tcx_pkg::DATA_W-8){imm[7]}}, imm};
      prod    = opnd_x * opnd_y;
      wr      = 1'b1;
      taken   = 1'b0;
      val     = '0;
      unique case (instr.mode)
         tcx_pkg::OP_AND: val = opnd_x & opnd_y;
         tcx_pkg::OP_OR:  val = opnd_x | opnd_y;
         tcx_pkg::OP_XOR: val = opnd_x ^ opnd_y;
         tcx_pkg::OP_NOT: val = ~opnd_x;
         tcx_pkg::OP_ADD: val = opnd_x + opnd_y;
         tcx_pkg::OP_SUB: val = opnd_x - opnd_y;
         tcx_pkg::OP_MUL: val = prod[tcx_pkg::DATA_W-1:0];
         tcx_pkg::OP_SLT: begin
            val = ($signed(opnd_x) < $signed(opnd_y)) ? tcx_pkg::SLT_TRUE : '0;
         end
         tcx_pkg::OP_SHL: val = {opnd_x[tcx_pkg::DATA_W-2:0], 1'b0};
         tcx_pkg::OP_SAR: val = {opnd_x[tcx_pkg::DATA_W-1], opnd_x[tcx_pkg::DATA_W-1:1]};
         tcx_pkg::OP_MOV: val = opnd_x;
         tcx_pkg::OP_LIT: val = {{(tcx_pkg::DATA_W-4){1'b0}}, instr.field_c};
         tcx_pkg::OP_IMM: val = imm_ext;
         tcx_pkg::OP_JMP: begin
            wr    = 1'b0;
            taken = 1'b1;
         end
         // port x carries the tested register for branches
         tcx_pkg::OP_BZ: begin
            wr    = 1'b0;
            taken = (opnd_x == '0);
         end
         tcx_pkg::OP_BNZ: begin
            wr    = 1'b0;
            taken = (opnd_x != '0);
         end
      endcase
      offset = taken ? imm_ext[tcx_pkg::PC_W-1:0] : tcx_pkg::PC_W'(1);
      npc    = pc + offset;

      result.next_pc        = npc;
      result.write_happened = wr;
      result.write_index    = wr ? instr.field_a : '0;
      result.write_value    = wr ? val : '0;
      result.finished       = ({1'b0, npc} >= program_length);
   end

endmodule

// ----- hdl/tiny_16bit_cpu_execute_step.sv -----
// Execute step of a small 16-bit processor: takes one four-nibble instruction
// per req beat and returns one rsp beat with the next pc, the register
// write-back and the finished flag. One instruction per clock is sustained
// while rsp_tready stays high; the register file read is registered at the
// edge that takes the beat, and the execute result is loaded into the output
// register once it is empty or being taken, which offers the beat's result.
// req_tready drops while a stalled result holds the execute stage, and a
// write is forwarded to the following instruction. Program length is set at
// csr byte address 0. Depends on tcx_pkg, tcx_regfile and tcx_exec.

module tiny_16bit_cpu_execute_step (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // mode[3:0], field_a[7:4], field_b[11:8], field_c[15:12]
   input  logic [tcx_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // next_pc[11:0], write_happened[12], write_index[16:13],
   // write_value[32:17], finished[33], zero[39:34]
   output logic [tcx_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tcx_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   tcx_pkg::instr_type         req_instr;
   tcx_pkg::instr_type         s1_instr_ff;
   logic                       s1_valid_ff;
   logic                       rsp_valid_ff;
   tcx_pkg::result_type        rsp_data_ff;
   logic [tcx_pkg::PC_W-1:0]   pc_ff;
   logic [tcx_pkg::PLEN_W-1:0] plen_ff;
   logic                       accept;
   logic                       advance;
   logic [tcx_pkg::REG_AW-1:0] rd_addr0;
   logic [tcx_pkg::DATA_W-1:0] opnd_x;
   logic [tcx_pkg::DATA_W-1:0] opnd_y;
   tcx_pkg::result_type        result;
   tcx_pkg::rf_write_type      rf_wr;

   assign req_instr  = tcx_pkg::instr_type'(req_tdata);
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign rd_addr0   = (req_instr.mode == tcx_pkg::OP_BZ || req_instr.mode == tcx_pkg::OP_BNZ)
                       ? req_instr.field_a : req_instr.field_b;

   assign rf_wr.en   = advance && result.write_happened;
   assign rf_wr.addr = s1_instr_ff.field_a;
   assign rf_wr.data = result.write_value;

   tcx_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr0(rd_addr0),
      .rd_addr1(req_instr.field_c),
      .rd_data0(opnd_x),
      .rd_data1(opnd_y),
      .wr      (rf_wr)
   );

   tcx_exec u_exec (
      .instr         (s1_instr_ff),
      .opnd_x        (opnd_x),
      .opnd_y        (opnd_y),
      .pc            (pc_ff),
      .program_length(plen_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         plen_ff      <= tcx_pkg::PLEN_RESET;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= result.next_pc;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == tcx_pkg::CSR_PROGRAM_LENGTH) begin
            plen_ff <= csr_pwdata[tcx_pkg::PLEN_W-1:0];
         end
      end
      if (accept) begin
         s1_instr_ff <= req_instr;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tcx_pkg::RSP_TDATA_W - $bits(tcx_pkg::result_type)){1'b0}},
                        rsp_data_ff};

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == tcx_pkg::CSR_PROGRAM_LENGTH)
                       ? {{(32-tcx_pkg::PLEN_W){1'b0}}, plen_ff} : '0;

endmodule

// ----- hdl/tcx_checker.sv -----
// tcx_checker: port-level assertions for the execute step block, bound to
// the top level; depends on tcx_pkg and tiny_16bit_cpu_execute_step

module tcx_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tcx_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // no write-back means zero index and value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[12] |-> rsp_tdata[32:13] == '0)
      else $error("write fields set without a write");

   // an accepted beat into an empty output passes the operand register and then the output register
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |-> ##2 rsp_tvalid)
      else $error("result beat missing after accept");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind tiny_16bit_cpu_execute_step tcx_checker u_tcx_checker (.*);
